// ----- hdl/ps2m_pkg.sv -----
// Package for the PS/2 mouse cursor tracker: shared types, register indexes
// and the axis limit function. No dependencies.
package ps2m_pkg;

    localparam int unsigned CFG_W   = 13;
    localparam int unsigned POS_W   = 12;
    localparam int unsigned IDX_W   = 2;

    localparam logic [IDX_W-1:0] CFG_WHEEL_MODE    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd2;

    localparam logic [CFG_W-1:0] X_MARGIN = 13'd12;
    localparam logic [CFG_W-1:0] Y_MARGIN = 13'd16;
    localparam logic [POS_W-1:0] POS_MAX  = 12'hFFF;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd1024;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd768;
    localparam logic [POS_W-1:0] POS_X_RESET  = 12'd512;
    localparam logic [POS_W-1:0] POS_Y_RESET  = 12'd384;

    localparam logic [7:0] HDR_OVF_MASK = 8'hC0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       from_aux;
    } in_word_t;

    typedef struct packed {
        logic             wheel_mode;
        logic [POS_W-1:0] limit_x;
        logic [POS_W-1:0] limit_y;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0] cursor_x;
        logic [POS_W-1:0] cursor_y;
        logic             left_button;
        logic             right_button;
        logic             left_pressed;
        logic             left_released;
        logic             right_changed;
        logic [7:0]       wheel_delta;
    } result_t;

    // Largest cursor position for one axis: size - margin, saturated to 0..POS_MAX.
    function automatic logic [POS_W-1:0] axis_limit(input logic [CFG_W-1:0] size,
                                                     input logic [CFG_W-1:0] margin);
        logic [CFG_W-1:0] diff;
        diff = size - margin;
        if (size < margin)
            return '0;
        else if (diff > {1'b0, POS_MAX})
            return POS_MAX;
        else
            return diff[POS_W-1:0];
    endfunction

endpackage

// ----- hdl/ps2_mouse_packet_cursor_tracker_unit.sv -----
// Top level of the PS/2 mouse packet decoder and cursor tracker.
// Depends on ps2m_pkg, ps2m_cfg_regs, ps2m_in_stage and ps2m_tracker.
//
// Usage:
//   Input channel: one controller byte per word (data_byte, from_aux) with
//   in_valid / in_stall. Bytes with from_aux low are taken and dropped.
//   Output channel: one word per good packet (cursor position, buttons,
//   left press/release edges, right change, wheel delta) with out_valid /
//   out_stall. Packets whose header carries an overflow bit give no word.
//   Config: cfg_we / cfg_index / cfg_data, single-cycle writes, only while
//   idle. Index 0 wheel mode, 1 screen width, 2 screen height; 3 is ignored.
// Path: the edge that takes the packet's last byte loads the input
//   register; when the tracker advances, it loads the result register and
//   raises out_valid.
// Throughput: one byte per cycle unless out_stall holds a shown word; the
//   input register and the result register form a two-stage pipe that
//   advances whenever the result register is empty or being taken.
// Stall: while out_stall holds a shown word, the tracker freezes; one more
//   byte is held in the input register, then in_stall rises.
// Reset: cursor at (512, 384), buttons released, byte counter cleared,
//   wheel mode off, screen 1024 x 768. Reset is asynchronous, active low.
module ps2_mouse_packet_cursor_tracker_unit (
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 data_byte,
    input  logic                       from_aux,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [11:0]                cursor_x,
    output logic [11:0]                cursor_y,
    output logic                       left_button,
    output logic                       right_button,
    output logic                       left_pressed,
    output logic                       left_released,
    output logic                       right_changed,
    output logic signed [7:0]          wheel_delta,

    input  logic                       cfg_we,
    input  logic [ps2m_pkg::IDX_W-1:0] cfg_index,
    input  logic [ps2m_pkg::CFG_W-1:0] cfg_data
);
    import ps2m_pkg::*;

    cfg_t     cfg;
    in_word_t s1_word;
    logic     s1_valid;
    logic     advance;
    result_t  res;

    // Limits are precomputed on each write.
    ps2m_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage 1: input register.
    ps2m_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .data_byte (data_byte),
        .from_aux  (from_aux),
        .in_stall  (in_stall),
        .advance   (advance),
        .s1_valid  (s1_valid),
        .s1_word   (s1_word)
    );

    // Stage 2: packet assembly, cursor clamp, result register.
    ps2m_tracker u_trk (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_word   (s1_word),
        .cfg       (cfg),
        .advance   (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign cursor_x      = res.cursor_x;
    assign cursor_y      = res.cursor_y;
    assign left_button   = res.left_button;
    assign right_button  = res.right_button;
    assign left_pressed  = res.left_pressed;
    assign left_released = res.left_released;
    assign right_changed = res.right_changed;
    assign wheel_delta   = $signed(res.wheel_delta);

endmodule

// ----- hdl/ps2m_cfg_regs.sv -----
// Configuration registers: wheel mode and per-axis cursor limits.
// Depends on ps2m_pkg.
module ps2m_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [ps2m_pkg::IDX_W-1:0] cfg_index,
    input  logic [ps2m_pkg::CFG_W-1:0] cfg_data,
    output ps2m_pkg::cfg_t             cfg
);
    import ps2m_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Limits are computed once at write time, keeping the datapath short.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_WHEEL_MODE:    cfg_next.wheel_mode = cfg_data[0];
                CFG_SCREEN_WIDTH:  cfg_next.limit_x    = axis_limit(cfg_data, X_MARGIN);
                CFG_SCREEN_HEIGHT: cfg_next.limit_y    = axis_limit(cfg_data, Y_MARGIN);
                default:           cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wheel_mode <= 1'b0;
            cfg_reg.limit_x    <= axis_limit(WIDTH_RESET, X_MARGIN);
            cfg_reg.limit_y    <= axis_limit(HEIGHT_RESET, Y_MARGIN);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/ps2m_in_stage.sv -----
// Input register stage: captures one word per cycle, stalls only when the
// tracker stage cannot advance. Depends on ps2m_pkg.
module ps2m_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [7:0]         data_byte,
    input  logic               from_aux,
    output logic               in_stall,
    input  logic               advance,
    output logic               s1_valid,
    output ps2m_pkg::in_word_t s1_word
);
    import ps2m_pkg::*;

    logic     s1_valid_reg;
    logic     s1_valid_next;
    in_word_t s1_word_reg;
    in_word_t s1_word_next;

    assign in_stall = s1_valid_reg && !advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_word_next  = s1_word_reg;
        if (!in_stall)
        begin
            s1_valid_next = in_valid;
            if (in_valid)
            begin
                s1_word_next.data_byte = data_byte;
                s1_word_next.from_aux  = from_aux;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        s1_word_reg <= s1_word_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_word  = s1_word_reg;

endmodule

// ----- hdl/ps2m_tracker.sv -----
// Packet assembly, cursor update and result register.
// Depends on ps2m_pkg.
module ps2m_tracker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s1_valid,
    input  ps2m_pkg::in_word_t s1_word,
    input  ps2m_pkg::cfg_t     cfg,
    output logic               advance,
    output logic               out_valid,
    input  logic               out_stall,
    output ps2m_pkg::result_t  res
);
    import ps2m_pkg::*;

    logic [1:0]       count_reg, count_next;
    logic [7:0]       pkt0_reg, pkt1_reg, pkt2_reg;
    logic [POS_W-1:0] pos_x_reg, pos_x_next;
    logic [POS_W-1:0] pos_y_reg, pos_y_next;
    logic             prev_left_reg, prev_left_next;
    logic             prev_right_reg, prev_right_next;
    logic             out_valid_reg, out_valid_next;
    result_t          res_reg, res_next;

    logic             go;
    logic             done;
    logic             emit;
    logic [7:0]       b;
    logic [7:0]       hdr;
    logic [7:0]       dx_byte;
    logic [7:0]       dy_byte;
    logic [POS_W+1:0] sum_x;
    logic [POS_W+1:0] sum_y;
    logic [POS_W-1:0] new_x;
    logic [POS_W-1:0] new_y;
    logic             left;
    logic             right;

    assign advance = !(out_valid_reg && out_stall);
    assign go      = advance && s1_valid && s1_word.from_aux;
    assign b       = s1_word.data_byte;

    // Packet ends on byte 3 in 3-byte mode, or on byte 4 (also when wheel
    // mode was dropped with three bytes already held).
    assign done = (count_reg == 2'd3) || ((count_reg == 2'd2) && !cfg.wheel_mode);

    // In 3-byte mode the Y byte is the one arriving now.
    assign hdr     = pkt0_reg;
    assign dx_byte = pkt1_reg;
    assign dy_byte = (count_reg == 2'd2) ? b : pkt2_reg;
    assign emit    = go && done && ((hdr & HDR_OVF_MASK) == 8'h00);

    assign sum_x = {2'b00, pos_x_reg} + {{(POS_W-6){dx_byte[7]}}, dx_byte};
    assign sum_y = {2'b00, pos_y_reg} - {{(POS_W-6){dy_byte[7]}}, dy_byte};

    always_comb
    begin
        if (sum_x[POS_W+1])
            new_x = '0;
        else if (sum_x[POS_W:0] > {1'b0, cfg.limit_x})
            new_x = cfg.limit_x;
        else
            new_x = sum_x[POS_W-1:0];

        if (sum_y[POS_W+1])
            new_y = '0;
        else if (sum_y[POS_W:0] > {1'b0, cfg.limit_y})
            new_y = cfg.limit_y;
        else
            new_y = sum_y[POS_W-1:0];
    end

    assign left  = hdr[0];
    assign right = hdr[1];

    always_comb
    begin
        count_next      = count_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        prev_left_next  = prev_left_reg;
        prev_right_next = prev_right_reg;
        out_valid_next  = out_valid_reg;
        res_next        = res_reg;

        if (advance)
            out_valid_next = emit;

        if (go)
            count_next = done ? 2'd0 : count_reg + 2'd1;

        if (emit)
        begin
            pos_x_next             = new_x;
            pos_y_next             = new_y;
            prev_left_next         = left;
            prev_right_next        = right;
            res_next.cursor_x      = new_x;
            res_next.cursor_y      = new_y;
            res_next.left_button   = left;
            res_next.right_button  = right;
            res_next.left_pressed  = left && !prev_left_reg;
            res_next.left_released = !left && prev_left_reg;
            res_next.right_changed = right != prev_right_reg;
            res_next.wheel_delta   = ((count_reg == 2'd3) && cfg.wheel_mode) ? b : 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= 2'd0;
            pos_x_reg      <= POS_X_RESET;
            pos_y_reg      <= POS_Y_RESET;
            prev_left_reg  <= 1'b0;
            prev_right_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            prev_left_reg  <= prev_left_next;
            prev_right_reg <= prev_right_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Packet byte store and result register, no reset.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (go && (count_reg == 2'd0))
            pkt0_reg <= b;
        if (go && (count_reg == 2'd1))
            pkt1_reg <= b;
        if (go && (count_reg == 2'd2))
            pkt2_reg <= b;
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    a_edges_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.left_pressed && res_reg.left_released))
        else $error("left press and release flagged together");

    a_press_implies_down: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.left_pressed) |-> res_reg.left_button)
        else $error("left press without left button down");

    a_history_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (prev_left_reg == res_reg.left_button
                           && prev_right_reg == res_reg.right_button))
        else $error("button history out of step with shown word");

    a_frozen_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> ($stable(pos_x_reg) && $stable(pos_y_reg)
                                          && $stable(count_reg)))
        else $error("tracker state moved while output stalled");

endmodule

// ----- verif/ps2_mouse_cursor_monitor.sv -----
`timescale 1ns / 1ps
// Cursor tracker monitor: follows the byte channel, the report channel and the
// config port, predicts every cursor report and compares it field by field.
// Depends on ps2m_pkg.
module ps2_mouse_cursor_monitor (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [7:0]                 data_byte,
    input  logic                       from_aux,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [11:0]                cursor_x,
    input  logic [11:0]                cursor_y,
    input  logic                       left_button,
    input  logic                       right_button,
    input  logic                       left_pressed,
    input  logic                       left_released,
    input  logic                       right_changed,
    input  logic [7:0]                 wheel_delta,
    input  logic                       cfg_we,
    input  logic [ps2m_pkg::IDX_W-1:0] cfg_index,
    input  logic [ps2m_pkg::CFG_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         reports_due
);
    import ps2m_pkg::*;

    // reports predicted but not yet seen on the output channel
    result_t          reports_q[$];
    result_t          seen;

    logic             wheel_on;
    logic [CFG_W-1:0] scr_w;
    logic [CFG_W-1:0] scr_h;

    logic [2:0]       byte_cnt;
    logic [7:0]       pkt_buf [0:2];
    int               pos_x;
    int               pos_y;
    logic             held_l;
    logic             held_r;

    // highest cursor coordinate on one axis
    function automatic int edge_of(input logic [CFG_W-1:0] size, input int margin);
        int room;
        room = int'(size) - margin;
        if (room < 0)
            return 0;
        if (room > int'(POS_MAX))
            return int'(POS_MAX);
        return room;
    endfunction

    function automatic int clip(input int v, input int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic take_byte(input logic [7:0] b);
        int         span;
        logic [7:0] wheel;
        logic       l;
        logic       r;
        result_t    rep;
        span  = wheel_on ? 4 : 3;
        wheel = '0;
        if (byte_cnt >= 3'd4)
            byte_cnt = '0;
        if (byte_cnt < 3'd3)
            pkt_buf[byte_cnt] = b;
        else if (wheel_on)
            wheel = b;
        byte_cnt = byte_cnt + 3'd1;
        if (int'(byte_cnt) < span)
            return;
        byte_cnt = '0;
        if ((pkt_buf[0] & HDR_OVF_MASK) != 8'h00)
            return;
        pos_x = clip(pos_x + int'($signed(pkt_buf[1])), edge_of(scr_w, int'(X_MARGIN)));
        pos_y = clip(pos_y - int'($signed(pkt_buf[2])), edge_of(scr_h, int'(Y_MARGIN)));
        l = pkt_buf[0][0];
        r = pkt_buf[0][1];
        rep.cursor_x      = pos_x[11:0];
        rep.cursor_y      = pos_y[11:0];
        rep.left_button   = l;
        rep.right_button  = r;
        rep.left_pressed  = l & ~held_l;
        rep.left_released = ~l & held_l;
        rep.right_changed = r ^ held_r;
        rep.wheel_delta   = wheel;
        held_l = l;
        held_r = r;
        reports_q.push_back(rep);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            if (mismatches < 10)
                $display("%0t: %s expected %0d, got %0d", $realtime, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reports_q.delete();
            mismatches  = 0;
            reports_due <= 0;
            wheel_on    = 1'b0;
            scr_w       = WIDTH_RESET;
            scr_h       = HEIGHT_RESET;
            byte_cnt    = '0;
            pos_x       = int'(POS_X_RESET);
            pos_y       = int'(POS_Y_RESET);
            held_l      = 1'b0;
            held_r      = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (reports_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: report word with none outstanding", $realtime);
                    mismatches++;
                end
                else
                begin
                    seen = reports_q.pop_front();
                    check_field("cursor_x", seen.cursor_x, cursor_x);
                    check_field("cursor_y", seen.cursor_y, cursor_y);
                    check_field("left_button", seen.left_button, left_button);
                    check_field("right_button", seen.right_button, right_button);
                    check_field("left_pressed", seen.left_pressed, left_pressed);
                    check_field("left_released", seen.left_released, left_released);
                    check_field("right_changed", seen.right_changed, right_changed);
                    check_field("wheel_delta", seen.wheel_delta, wheel_delta);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WHEEL_MODE:    wheel_on = cfg_data[0];
                    CFG_SCREEN_WIDTH:  scr_w = cfg_data;
                    CFG_SCREEN_HEIGHT: scr_h = cfg_data;
                    default:           ;
                endcase
            end
            if (in_valid && !in_stall && from_aux)
                take_byte(data_byte);
            reports_due <= reports_q.size();
        end
    end

endmodule

// ----- verif/ps2_mouse_packet_cursor_tracker_unit_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the PS/2 mouse cursor tracker: drives bytes, config writes
// and output stalls, and gives the verdict. Depends on ps2m_pkg, the block and
// ps2_mouse_cursor_monitor, which does all prediction and checking.
module ps2_mouse_packet_cursor_tracker_unit_test;
    import ps2m_pkg::*;

    // index 3 has no register behind it; written once to see it is ignored
    localparam logic [IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int PHASES       = 8;
    localparam int PHASE_BYTES  = 140;  // mouse bytes per random phase
    localparam int DRAIN_CYCLES = 4;    // input reg + result reg, with margin
    localparam int RUN_LIMIT_NS = 800000;

    // idle patterns, one per phase in turn
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic [7:0]       data_byte = '0;
    logic             from_aux  = 1'b0;
    logic             out_stall = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data  = '0;

    logic             in_stall;
    logic             out_valid;
    logic [11:0]      cursor_x;
    logic [11:0]      cursor_y;
    logic             left_button;
    logic             right_button;
    logic             left_pressed;
    logic             left_released;
    logic             right_changed;
    logic signed [7:0] wheel_delta;

    int               mismatches;
    int               reports_due;

    int               send_idle_pct = 0;
    int               stall_pct     = 0;
    logic             wheel_now     = 1'b0;

    // screen settings for the random phases: default, common sizes, the range
    // ends, a width and height below their margins and several above the 12-bit limit
    logic             phase_wheel  [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    logic [CFG_W-1:0] phase_width  [PHASES] = '{13'd1024, 13'd640, 13'd16, 13'd4096,
                                               13'd8191, 13'd5, 13'd100, 13'd4096};
    logic [CFG_W-1:0] phase_height [PHASES] = '{13'd768, 13'd480, 13'd16, 13'd4096,
                                               13'd8191, 13'd10, 13'd4096, 13'd16};

    ps2_mouse_packet_cursor_tracker_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .from_aux      (from_aux),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cursor_x      (cursor_x),
        .cursor_y      (cursor_y),
        .left_button   (left_button),
        .right_button  (right_button),
        .left_pressed  (left_pressed),
        .left_released (left_released),
        .right_changed (right_changed),
        .wheel_delta   (wheel_delta),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    ps2_mouse_cursor_monitor monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .from_aux      (from_aux),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cursor_x      (cursor_x),
        .cursor_y      (cursor_y),
        .left_button   (left_button),
        .right_button  (right_button),
        .left_pressed  (left_pressed),
        .left_released (left_released),
        .right_changed (right_changed),
        .wheel_delta   (wheel_delta),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .reports_due   (reports_due)
    );

    always #1 clk = ~clk;

    // receiver: stall picked fresh every cycle; 0 % means never
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // Hang guard, far beyond the slowest legal run.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("[ps2_mouse_packet_cursor_tracker_unit] ERROR");
        $finish;
    end

    // One word on the byte channel. Called right after the clock rises; may idle
    // first, then holds the word until it is taken. Valid is left high so
    // back-to-back words need no second assignment at the same instant.
    task automatic put_byte(input logic [7:0] b, input logic aux);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        from_aux  <= aux;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Whole mouse packet; the wheel byte only goes out in wheel mode.
    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx,
                               input logic [7:0] dy, input logic [7:0] wheel);
        put_byte(hdr, 1'b1);
        put_byte(dx, 1'b1);
        put_byte(dy, 1'b1);
        if (wheel_now)
            put_byte(wheel, 1'b1);
    endtask

    // Stop sending and wait until every report is in, plus the pipe depth so
    // a dropped packet's last byte has also gone through the tracker.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_screen(input logic wheel, input logic [CFG_W-1:0] w,
                              input logic [CFG_W-1:0] h);
        write_reg(CFG_WHEEL_MODE, {{(CFG_W-1){1'b0}}, wheel});
        write_reg(CFG_SCREEN_WIDTH, w);
        write_reg(CFG_SCREEN_HEIGHT, h);
        cfg_we    <= 1'b0;
        wheel_now = wheel;
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 52; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 52; end
            IDLE_BOTH:     begin send_idle_pct = 8;  stall_pct = 8;  end
            default:       begin send_idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // Delta byte; with drift on, mostly pushes one way so the cursor reaches
    // the screen edges and sits on the clamp.
    function automatic logic [7:0] pick_delta(input bit drift, input bit up);
        if (drift && $urandom_range(0, 3) != 0)
            return up ? 8'($urandom_range(1, 127)) : 8'($urandom_range(128, 255));
        return 8'($urandom);
    endfunction

    // Random traffic: mostly good packets, some with overflow headers,
    // non-mouse noise and lone mouse bytes that shift packet framing.
    task automatic run_traffic(input int n_bytes);
        int         sent;
        int         pick;
        bit         drift;
        bit         dir_x;
        bit         dir_y;
        logic [7:0] hdr;
        sent  = 0;
        drift = $urandom_range(0, 1);
        dir_x = $urandom_range(0, 1);
        dir_y = $urandom_range(0, 1);
        while (sent < n_bytes)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                put_byte(8'($urandom), 1'b0);
            else if (pick < 12)
            begin
                put_byte(8'($urandom), 1'b1);
                sent++;
            end
            else
            begin
                hdr = 8'($urandom);
                if (pick >= 22)
                    hdr = hdr & ~HDR_OVF_MASK;
                send_packet(hdr, pick_delta(drift, dir_x), pick_delta(drift, dir_y),
                            8'($urandom));
                sent += wheel_now ? 4 : 3;
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset config, no idling.
        put_byte(8'hFF, 1'b0);                          // other port: dropped
        send_packet(8'h09, 8'h7F, 8'h80, 8'h00);        // left down, max +x, min y
        send_packet(8'h0A, 8'h80, 8'h7F, 8'h00);        // left up, right down
        send_packet(8'hC3, 8'h10, 8'h10, 8'h00);        // both overflow bits
        send_packet(8'h48, 8'h01, 8'h01, 8'h00);        // x overflow only
        send_packet(8'h88, 8'h01, 8'h01, 8'h00);        // y overflow only
        settle();

        // Spare index must not disturb anything; then tiny screen, wheel on.
        write_reg(CFG_SPARE, '1);
        set_screen(1'b1, 13'd16, 13'd16);
        send_packet(8'h03, 8'h05, 8'h00, 8'h85);        // clamps x to 4, y to 0

        // Wheel mode dropped with three bytes held: next byte ends the packet
        // and its content is not used as wheel delta.
        put_byte(8'h00, 1'b1);
        put_byte(8'h01, 1'b1);
        put_byte(8'hFF, 1'b1);
        settle();
        set_screen(1'b0, 13'd16, 13'd16);
        put_byte(8'h77, 1'b1);

        // Random phases, each with its own screen setting and idle pattern.
        for (int i = 0; i < PHASES; i++)
        begin
            settle();
            set_screen(phase_wheel[i], phase_width[i], phase_height[i]);
            set_idling(idle_mode_t'(i % 4));
            run_traffic(PHASE_BYTES);
        end
        settle();

        if (mismatches == 0 && reports_due == 0)
            $display("[ps2_mouse_packet_cursor_tracker_unit] OK");
        else
            $display("[ps2_mouse_packet_cursor_tracker_unit] ERROR");
        $finish;
    end

endmodule
